FILE: rtl/percent_url_encoder_top_macros.svh
// Assertion macros for the percent URL encoder.
// Used by percent_url_encoder_top.sv; expects signals named clock and reset in scope.
`ifndef PERCENT_URL_ENCODER_TOP_MACROS_SVH
`define PERCENT_URL_ENCODER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define PUE_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("percent_url_encoder: assertion failed");
// Next-cycle implication, checked outside reset.
`define PUE_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("percent_url_encoder: assertion failed");
`else
`define PUE_ASSERT_NOW(lbl, ante, cons)
`define PUE_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: rtl/pue_pkg.sv
// Types, constants and character-class functions for the percent URL encoder.
// No dependencies; imported by percent_url_encoder_top.
package pue_pkg;

   typedef logic [7:0] char_type;
   typedef logic [1:0] mode_type;
   typedef logic [1:0] phase_type;

   // Punctuation sets selected by the mode register
   localparam mode_type MODE_ALL       = 2'd0;
   localparam mode_type MODE_COMPONENT = 2'd1;
   localparam mode_type MODE_FULL_URI  = 2'd2;
   localparam mode_type MODE_ESCAPE    = 2'd3;

   // Output character position within an encoded triple
   localparam phase_type PH_PCT = 2'd0;
   localparam phase_type PH_HI  = 2'd1;
   localparam phase_type PH_LO  = 2'd2;

   localparam char_type CHAR_PCT = 8'h25;

   function automatic logic is_alnum(input char_type b);
      return (b inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]});
   endfunction

   function automatic logic in_mode_set(input char_type b, input mode_type m);
      logic hit;
      hit = 1'b0;
      case (m)
         MODE_COMPONENT: begin
            hit = (b inside {"!", "'", "(", ")", "*", "-", ".", "_", "~"});
         end
         MODE_FULL_URI: begin
            hit = (b inside {"!", "#", "$", "&", "'", "(", ")", "*", "+", ",",
                             "-", ".", "/", ":", ";", "=", "?", "@", "_", "~"});
         end
         MODE_ESCAPE: begin
            hit = (b inside {"*", "+", "-", ".", "/", "@"});
         end
         default: begin
            hit = 1'b0;
         end
      endcase
      return hit;
   endfunction

   // True when the byte has to become a %XX triple
   function automatic logic needs_encode(input char_type b, input mode_type m);
      return !(is_alnum(b) || b[7] || in_mode_set(b, m));
   endfunction

   function automatic char_type hex_digit(input logic [3:0] n);
      char_type d;
      if (n > 4'd9) begin
         d = 8'h41 + {4'd0, n} - 8'd10;
      end else begin
         d = 8'h30 + {4'd0, n};
      end
      return d;
   endfunction

endpackage

FILE: rtl/percent_url_encoder_top.sv
// Percent URL encoder: byte stream in, URL-encoded character stream out.
// Depends on pue_pkg.sv and percent_url_encoder_top_macros.svh.
//
//   channel   dir  word               handshake
//   req_*     in   one raw byte       req_tvalid / req_tready
//   rsp_*     out  one output char    rsp_tvalid / rsp_tready, tlast ends a byte's run
//   csr_*     in   encode mode (2b)   csr_wen, no back-pressure
//
// A byte that passes unchanged occupies the single character output register as
// one word, an encoded byte as three ('%', high hex digit, low hex digit), each
// held until taken. An accepted byte goes into the input register, then moves
// into the output register once that is empty or finishing its run, and there
// its first character is presented. Reset (synchronous) empties both stages and
// sets the mode to encode-all. A stalled output holds its word; the input
// register can still take one byte while a finished word waits.
`include "percent_url_encoder_top_macros.svh"

module percent_url_encoder_top (
   input  logic             clock,
   input  logic             reset,
   // slave side
   input  logic             req_tvalid,
   output logic             req_tready,
   input  pue_pkg::char_type req_tdata,   // [7:0] in_byte
   // master side
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output pue_pkg::char_type rsp_tdata,   // [7:0] out_char
   output logic             rsp_tlast,    // last_of_run
   // configuration
   input  logic             csr_wen,
   input  pue_pkg::mode_type csr_wdata     // [1:0] encode_mode
);
   import pue_pkg::*;

   // Mode register
   mode_type  mode_ff, mode_in;

   // Input stage: byte plus its precomputed encode decision
   logic      in_valid_ff, in_valid_in;
   char_type  in_byte_ff, in_byte_in;
   logic      in_enc_ff, in_enc_in;

   // Output stage: byte being emitted and position within its run
   logic      out_valid_ff, out_valid_in;
   char_type  out_byte_ff, out_byte_in;
   logic      out_enc_ff, out_enc_in;
   phase_type out_phase_ff, out_phase_in;

   logic      out_last;
   logic      out_take;
   logic      out_done;
   logic      out_load;
   logic      in_take;

   // Last word of the run: a passed byte, or the low digit of a triple
   assign out_last = !out_enc_ff || (out_phase_ff == PH_LO);
   assign out_take = out_valid_ff && rsp_tready;
   assign out_done = out_take && out_last;
   // Refill the output stage when it is empty or finishes its run this cycle
   assign out_load = in_valid_ff && (!out_valid_ff || out_done);
   assign req_tready = !in_valid_ff || out_load;
   assign in_take = req_tvalid && req_tready;

   always_comb begin
      mode_in = csr_wen ? csr_wdata : mode_ff;
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_enc_in   = in_enc_ff;
      if (in_take) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_tdata;
         // Mode must only change while idle (the user's duty, not enforced here), so decide the class on entry
         in_enc_in   = needs_encode(req_tdata, mode_ff);
      end else if (out_load) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_enc_in   = out_enc_ff;
      out_phase_in = out_phase_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
         out_byte_in  = in_byte_ff;
         out_enc_in   = in_enc_ff;
         out_phase_in = PH_PCT;
      end else if (out_done) begin
         out_valid_in = 1'b0;
      end else if (out_take) begin
         // advance to the next character of the triple
         out_phase_in = out_phase_ff + 2'd1;
      end
   end

   always_comb begin
      case (out_phase_ff)
         PH_PCT:  rsp_tdata = out_enc_ff ? CHAR_PCT : out_byte_ff;
         PH_HI:   rsp_tdata = hex_digit(out_byte_ff[7:4]);
         PH_LO:   rsp_tdata = hex_digit(out_byte_ff[3:0]);
         default: rsp_tdata = out_byte_ff;
      endcase
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_ALL;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         out_phase_ff <= PH_PCT;
      end else begin
         mode_ff      <= mode_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         out_phase_ff <= out_phase_in;
      end
   end

   // payload: no reset needed
   always_ff @(posedge clock) begin
      in_byte_ff  <= in_byte_in;
      in_enc_ff   <= in_enc_in;
      out_byte_ff <= out_byte_in;
      out_enc_ff  <= out_enc_in;
   end

   `PUE_ASSERT_NOW(a_phase_only_when_encoding,
                   out_valid_ff && (out_phase_ff != PH_PCT), out_enc_ff)
   `PUE_ASSERT_NOW(a_phase_in_range, out_valid_ff, out_phase_ff != 2'd3)
   `PUE_ASSERT_NOW(a_triple_opens_with_pct,
                   out_valid_ff && out_enc_ff && (out_phase_ff == PH_PCT),
                   rsp_tdata == CHAR_PCT)
   `PUE_ASSERT_NEXT(a_mid_run_advances, out_take && !out_last,
                    out_valid_ff && (out_phase_ff == $past(out_phase_ff) + 2'd1))

endmodule
